// ----- rtl/mpg_pkg.sv -----
package mpg_pkg;

  localparam int IDX_W    = 12;
  localparam int AXIS_W   = 4;
  localparam int ENTRY_W  = 20;
  localparam int COORD_W  = 22;
  localparam int RECIP_W  = 17;
  localparam int PROD1_W  = IDX_W + RECIP_W;
  localparam int WEIGHT_W = 21;
  localparam int PROD_W   = ENTRY_W + WEIGHT_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int MAG_W    = SUM_W - 1;
  localparam int QUO_W    = 21;
  localparam int CFG_W    = 3 * ENTRY_W;
  localparam int REG_W    = 3;

  // Fractions are scaled by the common multiple of all sizes 1..16; the
  // result divides by twice that, 1441440 = 32 * 45045. Shift out the power
  // of two, then divide by the odd part with a reciprocal.
  localparam int DIV_SHIFT = 5;
  localparam int X_W       = MAG_W - 1 - DIV_SHIFT;
  localparam int SPLIT_W   = 18;
  localparam int DRECIP_W  = 21;
  localparam int PART_W    = SPLIT_W + DRECIP_W;
  localparam int EST_W     = X_W + DRECIP_W;
  localparam logic [X_W-1:0]      DIV_ODD   = 36'd45045;
  // floor(2^36 / 45045); the estimate is low by at most one
  localparam logic [DRECIP_W-1:0] DIV_RECIP = 21'd1525573;

  localparam logic [REG_W-1:0] REG_NUM_AXES = 3'd0;
  localparam logic [REG_W-1:0] REG_SIZE_A   = 3'd1;
  localparam logic [REG_W-1:0] REG_SIZE_B   = 3'd2;
  localparam logic [REG_W-1:0] REG_SIZE_C   = 3'd3;
  localparam logic [REG_W-1:0] REG_BASIS_X  = 3'd4;
  localparam logic [REG_W-1:0] REG_BASIS_Y  = 3'd5;
  localparam logic [REG_W-1:0] REG_BASIS_Z  = 3'd6;

  typedef struct packed {
    logic [AXIS_W-1:0]                qm1_a;
    logic [AXIS_W-1:0]                qm1_b;
    logic [AXIS_W-1:0]                qm1_c;
    logic [2:0][2:0][ENTRY_W-1:0]     basis;
  } cfg_t;

  typedef struct packed {
    logic [AXIS_W-1:0] na;
    logic [AXIS_W-1:0] nb;
    logic [AXIS_W-1:0] nc;
    logic              oor;
  } item_t;

  // Size clamped to 1..16, returned as size minus one.
  function automatic logic [AXIS_W-1:0] clamp_qm1(input logic [4:0] s);
    logic [4:0] d;
    d = s - 5'd1;
    if (s == 5'd0) return 4'd0;
    else if (s > 5'd16) return 4'd15;
    else return d[AXIS_W-1:0];
  endfunction

  // floor(65536 / q)
  function automatic logic [RECIP_W-1:0] recip(input logic [AXIS_W-1:0] qm1);
    logic [RECIP_W-1:0] r;
    unique case (qm1)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd32768;
      4'd2:  r = 17'd21845;
      4'd3:  r = 17'd16384;
      4'd4:  r = 17'd13107;
      4'd5:  r = 17'd10922;
      4'd6:  r = 17'd9362;
      4'd7:  r = 17'd8192;
      4'd8:  r = 17'd7281;
      4'd9:  r = 17'd6553;
      4'd10: r = 17'd5957;
      4'd11: r = 17'd5461;
      4'd12: r = 17'd5041;
      4'd13: r = 17'd4681;
      4'd14: r = 17'd4369;
      default: r = 17'd4096;
    endcase
    return r;
  endfunction

  // 720720 / q
  function automatic logic [ENTRY_W-1:0] lcm_over_q(input logic [AXIS_W-1:0] qm1);
    logic [ENTRY_W-1:0] r;
    unique case (qm1)
      4'd0:  r = 20'd720720;
      4'd1:  r = 20'd360360;
      4'd2:  r = 20'd240240;
      4'd3:  r = 20'd180180;
      4'd4:  r = 20'd144144;
      4'd5:  r = 20'd120120;
      4'd6:  r = 20'd102960;
      4'd7:  r = 20'd90090;
      4'd8:  r = 20'd80080;
      4'd9:  r = 20'd72072;
      4'd10: r = 20'd65520;
      4'd11: r = 20'd60060;
      4'd12: r = 20'd55440;
      4'd13: r = 20'd51480;
      4'd14: r = 20'd48048;
      default: r = 20'd45045;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/mpg_if.sv -----
interface mpg_in_if;
  import mpg_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] point_index;
  modport source (output valid, output point_index, input ready);
  modport sink   (input valid, input point_index, output ready);
endinterface

interface mpg_out_if;
  import mpg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic [AXIS_W-1:0]         axis_index_a;
  logic [AXIS_W-1:0]         axis_index_b;
  logic [AXIS_W-1:0]         axis_index_c;
  logic                      index_out_of_range;
  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  output axis_index_a, output axis_index_b, output axis_index_c,
                  output index_out_of_range, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  input axis_index_a, input axis_index_b, input axis_index_c,
                  input index_out_of_range, output ready);
endinterface

// ----- rtl/mpg_front.sv -----
module mpg_front (
  input  logic           clk,
  input  logic           rst,
  input  mpg_pkg::cfg_t  cfg,
  mpg_in_if.sink         in_ch,
  input  logic           q_ready,
  output logic           q_push,
  output mpg_pkg::item_t q_item
);
  import mpg_pkg::*;

  logic [5:0] v;
  logic       en;

  logic [IDX_W-1:0]   s1_idx, s2_idx;
  logic [PROD1_W-1:0] s2_p, s4_p;
  logic [IDX_W-1:0]   s3_t, s3_r, s4_rest, s5_t, s5_r;
  logic [AXIS_W-1:0]  s4_nc, s5_nc;
  item_t              s6_item;

  logic [4:0]         qa, qb, qc;
  logic [IDX_W-1:0]   t1, r1, t2, r2, rest, na, nb_full, nc_full;
  logic [16:0]        m1, m2;
  logic               ge1, ge2, oor;

  assign qa = {1'b0, cfg.qm1_a} + 5'd1;
  assign qb = {1'b0, cfg.qm1_b} + 5'd1;
  assign qc = {1'b0, cfg.qm1_c} + 5'd1;

  assign en          = !v[5] || q_ready;
  assign in_ch.ready = en;
  assign q_push      = v[5] && q_ready;
  assign q_item      = s6_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_ch.valid};
    end
  end

  // Divide by the fastest axis size, then by the middle one; a reciprocal
  // estimate is low by at most one and gets a single correction.
  always_comb begin
    t1      = s2_p[PROD1_W-2:16];
    m1      = t1 * qc;
    r1      = s2_idx - m1[IDX_W-1:0];
    ge1     = s3_r >= {7'd0, qc};
    nc_full = ge1 ? s3_r - {7'd0, qc} : s3_r;
    rest    = s3_t + {11'd0, ge1};
    t2      = s4_p[PROD1_W-2:16];
    m2      = t2 * qb;
    r2      = s4_rest - m2[IDX_W-1:0];
    ge2     = s5_r >= {7'd0, qb};
    nb_full = ge2 ? s5_r - {7'd0, qb} : s5_r;
    na      = s5_t + {11'd0, ge2};
    oor     = na >= {7'd0, qa};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_idx      <= in_ch.point_index;
      s2_idx      <= s1_idx;
      s2_p        <= s1_idx * recip(cfg.qm1_c);
      s3_t        <= t1;
      s3_r        <= r1;
      s4_nc       <= nc_full[AXIS_W-1:0];
      s4_rest     <= rest;
      s4_p        <= rest * recip(cfg.qm1_b);
      s5_t        <= t2;
      s5_r        <= r2;
      s5_nc       <= s4_nc;
      s6_item.oor <= oor;
      s6_item.na  <= oor ? '0 : na[AXIS_W-1:0];
      s6_item.nb  <= oor ? '0 : nb_full[AXIS_W-1:0];
      s6_item.nc  <= oor ? '0 : s5_nc;
    end
  end

endmodule

// ----- rtl/mpg_queue.sv -----
module mpg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mpg_pkg::item_t push_item,
  output logic           push_ready,
  input  logic           pop,
  output logic           not_empty,
  output mpg_pkg::item_t head
);
  import mpg_pkg::*;

  item_t      entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign not_empty  = count != 2'd0;
  assign push_ready = (count != 2'd2) || pop;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule

// ----- rtl/mpg_back.sv -----
module mpg_back (
  input  logic           clk,
  input  logic           rst,
  input  mpg_pkg::cfg_t  cfg,
  input  logic           q_not_empty,
  input  mpg_pkg::item_t q_head,
  output logic           q_pop,
  mpg_out_if.source      out_ch
);
  import mpg_pkg::*;

  logic       en;
  logic       v1, v2;
  logic [4:0] dv;

  item_t                              t1, t2, s0_tag, s1_tag, s2_tag, s3_tag;
  logic signed [2:0][WEIGHT_W-1:0]    w;
  logic signed [2:0][2:0][PROD_W-1:0] prod;

  logic [2:0]             s0_neg, s1_neg, s2_neg, s3_neg;
  logic [2:0][X_W-1:0]    s0_x, s1_x, s2_x, s3_r;
  logic [2:0][PART_W-1:0] s1_hi, s1_lo;
  logic [2:0][QUO_W-1:0]  s2_qe, s3_qe;

  logic [2:0][AXIS_W-1:0]          n_in, qm1_in;
  logic signed [2:0][WEIGHT_W-1:0] w_next;
  logic signed [2:0][SUM_W-1:0]    sum;
  logic [2:0][MAG_W-1:0]           mag;
  logic [2:0][EST_W-1:0]           est;
  logic [2:0][QUO_W-1:0]           quo;
  logic signed [2:0][COORD_W-1:0]  coord_next;

  assign en    = !dv[4] || out_ch.ready;
  assign q_pop = en && q_not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      dv <= '0;
    end else if (en) begin
      v1 <= q_not_empty;
      v2 <= v1;
      dv <= {dv[3:0], v2};
    end
  end

  // Weight per axis: (2n - q + 1) * (L / q), zero for a flagged index.
  always_comb begin
    logic signed [5:0]  m;
    logic signed [26:0] wp;
    n_in   = {q_head.na, q_head.nb, q_head.nc};
    qm1_in = {cfg.qm1_a, cfg.qm1_b, cfg.qm1_c};
    w_next = '0;
    for (int j = 0; j < 3; j++) begin
      m  = $signed({1'b0, n_in[2-j], 1'b0}) - $signed({2'b00, qm1_in[2-j]});
      wp = m * $signed({1'b0, lcm_over_q(qm1_in[2-j])});
      w_next[j] = q_head.oor ? '0 : wp[WEIGHT_W-1:0];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SUM_W'($signed(prod[r][0])) + SUM_W'($signed(prod[r][1])) +
               SUM_W'($signed(prod[r][2]));
      mag[r] = MAG_W'(sum[r][SUM_W-1] ? -sum[r] : sum[r]);
      est[r] = {s1_hi[r], {SPLIT_W{1'b0}}} + {{SPLIT_W{1'b0}}, s1_lo[r]};
      quo[r] = s3_qe[r] + {{(QUO_W-1){1'b0}}, s3_r[r] >= DIV_ODD};
      coord_next[r] = s3_neg[r] ? -COORD_W'({1'b0, quo[r]})
                                :  COORD_W'({1'b0, quo[r]});
    end
  end

  // Divide the magnitude by the constant: drop the power of two, multiply by
  // the reciprocal in two halves, then correct the estimate by one.
  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= q_head;
      w  <= w_next;
      t2 <= t1;
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          prod[r][j] <= $signed(cfg.basis[r][j]) * $signed(w[j]);
        end
      end
      s0_tag <= t2;
      s1_tag <= s0_tag;
      s2_tag <= s1_tag;
      s3_tag <= s2_tag;
      s1_neg <= s0_neg;
      s2_neg <= s1_neg;
      s3_neg <= s2_neg;
      s1_x   <= s0_x;
      s2_x   <= s1_x;
      s3_qe  <= s2_qe;
      for (int r = 0; r < 3; r++) begin
        s0_neg[r] <= sum[r][SUM_W-1];
        s0_x[r]   <= mag[r][MAG_W-2:DIV_SHIFT];
        s1_hi[r]  <= s0_x[r][X_W-1:SPLIT_W] * DIV_RECIP;
        s1_lo[r]  <= s0_x[r][SPLIT_W-1:0] * DIV_RECIP;
        s2_qe[r]  <= est[r][EST_W-1:X_W];
        s3_r[r]   <= s2_x[r] - s2_qe[r] * DIV_ODD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.coord_x            <= coord_next[0];
      out_ch.coord_y            <= coord_next[1];
      out_ch.coord_z            <= coord_next[2];
      out_ch.axis_index_a       <= s3_tag.na;
      out_ch.axis_index_b       <= s3_tag.nb;
      out_ch.axis_index_c       <= s3_tag.nc;
      out_ch.index_out_of_range <= s3_tag.oor;
    end
  end

  assign out_ch.valid = dv[4];

endmodule

// ----- rtl/monkhorst_pack_point_generator_top.sv -----
// Monkhorst-Pack grid point generator. Each transaction on in_ch carries a
// flat grid index and yields one transaction on out_ch with the cartesian
// point (Q5.16, truncated toward zero), the axis indices and an out-of-range
// flag. One index is taken every cycle while the output is not stalled. Six
// front stages decompose the index by reciprocal multiplication, a two-entry
// queue decouples them from the back pipeline, and
// seven back stages form the axis weights, the basis products and their sum,
// divide by the constant with a split reciprocal multiplication and a
// remainder check, and register the result. Write registers through
// cfg_we/cfg_index/cfg_data only while no transaction is in flight.
module monkhorst_pack_point_generator_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [mpg_pkg::REG_W-1:0] cfg_index,
  input  logic [mpg_pkg::CFG_W-1:0] cfg_data,
  mpg_in_if.sink                    in_ch,
  mpg_out_if.source                 out_ch
);
  import mpg_pkg::*;

  logic [1:0]       num_axes;
  logic [4:0]       size_a, size_b, size_c;
  logic [CFG_W-1:0] basis_x, basis_y, basis_z;
  logic [1:0]       axes;

  cfg_t  cfg;
  item_t f_item, q_head;
  logic  f_push, q_ready, q_pop, q_not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_axes <= 2'd3;
      size_a   <= 5'd4;
      size_b   <= 5'd4;
      size_c   <= 5'd4;
      basis_x  <= '0;
      basis_y  <= '0;
      basis_z  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_AXES: num_axes <= cfg_data[1:0];
        REG_SIZE_A:   size_a   <= cfg_data[4:0];
        REG_SIZE_B:   size_b   <= cfg_data[4:0];
        REG_SIZE_C:   size_c   <= cfg_data[4:0];
        REG_BASIS_X:  basis_x  <= cfg_data;
        REG_BASIS_Y:  basis_y  <= cfg_data;
        REG_BASIS_Z:  basis_z  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unused axes behave as size one and so drop out of both stages.
  always_comb begin
    axes      = (num_axes == 2'd0) ? 2'd1 : num_axes;
    cfg.qm1_a = clamp_qm1(size_a);
    cfg.qm1_b = (axes >= 2'd2) ? clamp_qm1(size_b) : '0;
    cfg.qm1_c = (axes == 2'd3) ? clamp_qm1(size_c) : '0;
    for (int j = 0; j < 3; j++) begin
      cfg.basis[0][j] = basis_x[j*ENTRY_W +: ENTRY_W];
      cfg.basis[1][j] = basis_y[j*ENTRY_W +: ENTRY_W];
      cfg.basis[2][j] = basis_z[j*ENTRY_W +: ENTRY_W];
    end
  end

  mpg_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .q_push  (f_push),
    .q_item  (f_item)
  );

  mpg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_item  (f_item),
    .push_ready (q_ready),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  mpg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

// ----- tb/sv/tb_monkhorst_pack_point_generator_top.sv -----
module tb_monkhorst_pack_point_generator_top;
  import mpg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [AXIS_W-1:0]         na;
    logic [AXIS_W-1:0]         nb;
    logic [AXIS_W-1:0]         nc;
    logic                      oor;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [REG_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  mpg_in_if  in_ch ();
  mpg_out_if out_ch ();

  monkhorst_pack_point_generator_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow registers
  logic [1:0]       sh_axes;
  logic [4:0]       sh_size [3];
  logic [CFG_W-1:0] sh_basis [3];

  logic [IDX_W-1:0] index_q [$];
  point_t           point_q [$];
  int               errors = 0;
  int               cycles = 0;
  int               pending = 0;
  bit               hold = 1'b0;
  bit               stim_done = 1'b0;

  function automatic point_t grid_point(input logic [IDX_W-1:0] idx);
    point_t p;
    longint q[3];
    longint n[3];
    longint total, rest, den, num, e;
    int axes;
    logic [ENTRY_W-1:0] raw;
    logic signed [COORD_W-1:0] c [3];
    p = '0;
    n = '{0, 0, 0};
    axes = (sh_axes == 0) ? 1 : sh_axes;
    total = 1;
    for (int j = 0; j < 3; j++) begin
      if (j < axes) q[j] = (sh_size[j] == 0) ? 1 : (sh_size[j] > 16 ? 16 : sh_size[j]);
      else q[j] = 1;
      total *= q[j];
    end
    if (idx >= total) begin
      p.oor = 1'b1;
      return p;
    end
    rest = idx;
    for (int j = axes - 1; j > 0; j--) begin
      n[j] = rest % q[j];
      rest /= q[j];
    end
    n[0] = rest;
    den = 2 * total;
    for (int r = 0; r < 3; r++) begin
      num = 0;
      for (int j = 0; j < axes; j++) begin
        raw = sh_basis[r][j*ENTRY_W +: ENTRY_W];
        e = longint'(signed'(raw));
        num += e * (2 * n[j] - q[j] + 1) * (total / q[j]);
      end
      c[r] = COORD_W'(num / den);
    end
    p.cx = c[0];
    p.cy = c[1];
    p.cz = c[2];
    p.na = n[0][3:0];
    p.nb = n[1][3:0];
    p.nc = n[2][3:0];
    return p;
  endfunction

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NUM_AXES: sh_axes = val[1:0];
      REG_SIZE_A, REG_SIZE_B, REG_SIZE_C: sh_size[idx - REG_SIZE_A] = val[4:0];
      REG_BASIS_X, REG_BASIS_Y, REG_BASIS_Z: sh_basis[idx - REG_BASIS_X] = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (index_q.size() == 0 && pending == 0 && point_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] rand_basis();
    return CFG_W'({$urandom(), $urandom()});
  endfunction

  task automatic set_grid(input logic [1:0] ax, input logic [4:0] a, input logic [4:0] b,
                          input logic [4:0] c);
    drain();
    write_reg(REG_NUM_AXES, CFG_W'(ax));
    write_reg(REG_SIZE_A, CFG_W'(a));
    write_reg(REG_SIZE_B, CFG_W'(b));
    write_reg(REG_SIZE_C, CFG_W'(c));
    write_reg(REG_BASIS_X, rand_basis());
    write_reg(REG_BASIS_Y, rand_basis());
    write_reg(REG_BASIS_Z, rand_basis());
  endtask

  // random index biased into the grid
  function automatic logic [IDX_W-1:0] rand_index();
    int axes, total;
    axes = (sh_axes == 0) ? 1 : sh_axes;
    total = 1;
    for (int j = 0; j < axes; j++)
      total *= (sh_size[j] == 0) ? 1 : (sh_size[j] > 16 ? 16 : sh_size[j]);
    if ($urandom_range(9) == 0) return IDX_W'($urandom());
    return IDX_W'($urandom_range(total - 1 < 4095 ? total : 4095, 0));
  endfunction

  // driver: bursts and gaps
  int burst = 0, gap = 0;
  logic [IDX_W-1:0] cur_idx;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.point_index <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        point_q.push_back(grid_point(in_ch.point_index));
        pending--;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap > 0) begin
          gap--;
          in_ch.valid <= 1'b0;
        end else if (index_q.size() > 0 && !hold) begin
          cur_idx = index_q.pop_front();
          in_ch.point_index <= cur_idx;
          in_ch.valid <= 1'b1;
          pending++;
          if (burst > 0) burst--;
          else begin
            burst = $urandom_range(30, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  point_t got, want;
  int stall_phase = 0;
  always @(posedge clk) begin
    cycles++;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.coord_x, out_ch.coord_y, out_ch.coord_z, out_ch.axis_index_a,
                out_ch.axis_index_b, out_ch.axis_index_c, out_ch.index_out_of_range};
        if (point_q.size() == 0) begin
          $error("unexpected transaction");
          errors++;
        end else begin
          want = point_q.pop_front();
          if (got.cx !== want.cx) begin
            $error("coord_x expected %0d got %0d", want.cx, got.cx); errors++;
          end
          if (got.cy !== want.cy) begin
            $error("coord_y expected %0d got %0d", want.cy, got.cy); errors++;
          end
          if (got.cz !== want.cz) begin
            $error("coord_z expected %0d got %0d", want.cz, got.cz); errors++;
          end
          if (got.na !== want.na) begin
            $error("axis_index_a expected %0d got %0d", want.na, got.na); errors++;
          end
          if (got.nb !== want.nb) begin
            $error("axis_index_b expected %0d got %0d", want.nb, got.nb); errors++;
          end
          if (got.nc !== want.nc) begin
            $error("axis_index_c expected %0d got %0d", want.nc, got.nc); errors++;
          end
          if (got.oor !== want.oor) begin
            $error("index_out_of_range expected %0d got %0d", want.oor, got.oor); errors++;
          end
        end
      end
      stall_phase = (stall_phase + 1) % 64;
      if (stall_phase < 24) out_ch.ready <= 1'b1;
      else if (stall_phase < 40) out_ch.ready <= ($urandom_range(2) != 0);
      else out_ch.ready <= ($urandom_range(3) == 0);
    end
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [4:0] a, b, c;
    sh_axes = 2'd3;
    sh_size = '{5'd4, 5'd4, 5'd4};
    sh_basis = '{default: '0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset config: zero basis, 4x4x4
    index_q.push_back(12'd0);
    index_q.push_back(12'd63);
    index_q.push_back(12'd64);
    index_q.push_back(12'hFFF);
    // extreme basis entries, max sizes
    drain();
    write_reg(REG_BASIS_X, {3{20'h7FFFF}});
    write_reg(REG_BASIS_Y, {3{20'h80000}});
    write_reg(REG_BASIS_Z, {20'h80000, 20'h7FFFF, 20'h00001});
    write_reg(REG_SIZE_A, CFG_W'(16));
    write_reg(REG_SIZE_B, CFG_W'(16));
    write_reg(REG_SIZE_C, CFG_W'(16));
    index_q.push_back(12'd0);
    index_q.push_back(12'd4095);
    index_q.push_back(12'd2730);
    index_q.push_back(12'd1365);
    // saturated and zero sizes, axis count zero
    drain();
    write_reg(REG_SIZE_A, CFG_W'(31));
    write_reg(REG_SIZE_B, CFG_W'(0));
    write_reg(REG_NUM_AXES, CFG_W'(0));
    index_q.push_back(12'd15);
    index_q.push_back(12'd16);
    index_q.push_back(12'd7);
    drain();
    write_reg(REG_NUM_AXES, CFG_W'(2));
    index_q.push_back(12'd15);
    index_q.push_back(12'd16);
    drain();
    write_reg(REG_NUM_AXES, CFG_W'(1));
    write_reg(REG_SIZE_A, CFG_W'(1));
    index_q.push_back(12'd0);
    index_q.push_back(12'd1);
    // out-of-range register index is ignored
    drain();
    write_reg(3'd7, {CFG_W{1'b1}});
    index_q.push_back(12'd0);

    for (int ph = 0; ph < 16; ph++) begin
      a = 5'($urandom_range(31));
      b = 5'($urandom_range(31));
      c = 5'($urandom_range(31));
      if (ph == 0) begin a = 5'd16; b = 5'd16; c = 5'd16; end
      if (ph == 1) begin a = 5'd1; b = 5'd1; c = 5'd1; end
      set_grid(ph == 2 ? 2'd3 : 2'($urandom_range(3)), a, b, c);
      for (int i = 0; i < 50; i++) index_q.push_back(rand_index());
      if (ph == 8) begin
        wait (index_q.size() < 25);
        hold = 1'b1;
        wait (pending == 0 && point_q.size() == 0);
        hold = 1'b0;
      end
    end
    drain();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/mpg_pkg.sv
rtl/mpg_if.sv
rtl/mpg_front.sv
rtl/mpg_queue.sv
rtl/mpg_back.sv
rtl/monkhorst_pack_point_generator_top.sv
tb/sv/tb_monkhorst_pack_point_generator_top.sv
